FILE: rtl/core/stl_pkg.sv
package stl_pkg;

   localparam int POS_BITS_DEF = 16;
   localparam int TOK_W        = 16;

   // scan modes
   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_WORD  = 3'd1;
   localparam logic [2:0] M_INT   = 3'd2;
   localparam logic [2:0] M_STR   = 3'd3;
   localparam logic [2:0] M_EQ    = 3'd4;
   localparam logic [2:0] M_PLUS  = 3'd5;
   localparam logic [2:0] M_MINUS = 3'd6;
   localparam logic [2:0] M_BANG  = 3'd7;

   // token kinds
   localparam logic [4:0] K_END      = 5'd0;
   localparam logic [4:0] K_ILLEGAL  = 5'd1;
   localparam logic [4:0] K_WORD     = 5'd2;
   localparam logic [4:0] K_INT      = 5'd3;
   localparam logic [4:0] K_STRING   = 5'd4;
   localparam logic [4:0] K_ASSIGN   = 5'd5;
   localparam logic [4:0] K_EQ_EQ    = 5'd6;
   localparam logic [4:0] K_PLUS     = 5'd7;
   localparam logic [4:0] K_PLUS2    = 5'd8;
   localparam logic [4:0] K_MINUS    = 5'd9;
   localparam logic [4:0] K_MINUS2   = 5'd10;
   localparam logic [4:0] K_BANG     = 5'd11;
   localparam logic [4:0] K_NOT_EQ   = 5'd12;
   localparam logic [4:0] K_STAR     = 5'd13;
   localparam logic [4:0] K_SLASH    = 5'd14;
   localparam logic [4:0] K_LESS     = 5'd15;
   localparam logic [4:0] K_GREATER  = 5'd16;
   localparam logic [4:0] K_COMMA    = 5'd17;
   localparam logic [4:0] K_SEMI     = 5'd18;
   localparam logic [4:0] K_LPAREN   = 5'd19;
   localparam logic [4:0] K_RPAREN   = 5'd20;
   localparam logic [4:0] K_LBRACE   = 5'd21;
   localparam logic [4:0] K_RBRACE   = 5'd22;
   localparam logic [4:0] K_LBRACKET = 5'd23;
   localparam logic [4:0] K_RBRACKET = 5'd24;
   localparam logic [4:0] K_COLON    = 5'd25;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   typedef struct packed {
      logic [4:0]       kind;
      logic [TOK_W-1:0] start;
      logic [TOK_W-1:0] length;
      logic             ovf;
      logic             last;
   } token_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         8'h2A:   k = K_STAR;
         8'h2F:   k = K_SLASH;
         8'h3C:   k = K_LESS;
         8'h3E:   k = K_GREATER;
         8'h2C:   k = K_COMMA;
         8'h3B:   k = K_SEMI;
         8'h28:   k = K_LPAREN;
         8'h29:   k = K_RPAREN;
         8'h7B:   k = K_LBRACE;
         8'h7D:   k = K_RBRACE;
         8'h5B:   k = K_LBRACKET;
         8'h5D:   k = K_RBRACKET;
         8'h3A:   k = K_COLON;
         default: k = K_ILLEGAL;
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/core/script_token_lexer_unit.sv
// Script token lexer: turns a stream of source bytes into tokens.
// req channel: one source byte per beat in req_tdata[7:0]; a zero byte ends the
//   input, emits any open token and then an end token, and clears the position
//   counter and the overflow flag.
// rsp channel: one token per beat. rsp_tuser carries the kind, rsp_tdata the
//   start position, length and overflow flag, and rsp_tlast marks the final
//   token caused by one source byte (a byte causes zero, one or two tokens).
// Queue: a token enters the registered token queue when the byte that completes it
//   is accepted. Words, integers and strings complete on the first byte that
//   does not belong to them; = + - ! complete one byte later, after lookahead.
// Throughput: one byte per cycle while req_tready is high. All scanning is done
//   in one combinational pass from the mode/position registers into a three-entry
//   token queue; req_tready is high while the queue holds at most one token, so two
//   slots are always free for the next byte.
// Stall: while rsp_tready is low tokens pile up in the queue and req_tready
//   falls once two are waiting; nothing is dropped.
// Reset: synchronous, active high; empties the queue and returns the scanner
//   to idle at position zero with the overflow flag clear.
module script_token_lexer_unit #(
   parameter int POS_BITS = stl_pkg::POS_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] tok_start, [31:16] tok_length, [32] overflow
   output logic [4:0]  rsp_tuser,   // [4:0] tok_kind
   output logic        rsp_tlast    // last_of_run
);
   import stl_pkg::*;

   localparam int QDEPTH = 3;

   // scanner state
   logic [2:0]          mode_ff, mode_in;
   logic [POS_BITS-1:0] begin_ff, begin_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                ovf_ff, ovf_in;

   // token queue, entry 0 is the head
   token_type           q_ff [QDEPTH];
   token_type           q_in [QDEPTH];
   logic [1:0]          cnt_ff, cnt_in;

   logic                push, pop;
   token_type           slot0, slot1;
   logic [1:0]          n_tok;

   // scan of one byte
   always_comb begin
      logic [7:0]          c;
      logic [POS_BITS-1:0] p;
      logic [POS_BITS-1:0] lim;
      logic [POS_BITS-1:0] span;
      token_type           idle_tok, pe_tok;
      logic                idle_v, idle_end, pe_v, call_idle, ended, op_match;
      logic [2:0]          idle_mode;
      logic [POS_BITS-1:0] idle_begin;
      logic [4:0]          op_single, op_double;
      logic [7:0]          op_char;

      c    = req_tdata;
      p    = pos_ff;
      lim  = '1;
      span = (p > begin_ff) ? (p - begin_ff) : '0;

      // what a byte does when no token is open
      idle_v     = 1'b0;
      idle_end   = 1'b0;
      idle_mode  = M_IDLE;
      idle_begin = begin_ff;
      idle_tok   = '{kind: K_END, start: TOK_W'(p), length: '0, ovf: ovf_ff, last: 1'b0};
      if (c == CH_NUL) begin
         idle_v   = 1'b1;
         idle_end = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
         idle_v = 1'b0;
      end else begin
         idle_begin = p;
         if (is_letter(c)) begin
            idle_mode = M_WORD;
         end else if (is_digit(c)) begin
            idle_mode = M_INT;
         end else begin
            unique case (c)
               CH_QUOTE: begin
                  // string text begins after the quote, saturated at the limit
                  idle_begin = (p != lim) ? (p + 1'b1) : lim;
                  idle_mode  = M_STR;
               end
               CH_EQ:    idle_mode = M_EQ;
               CH_PLUS:  idle_mode = M_PLUS;
               CH_MINUS: idle_mode = M_MINUS;
               CH_BANG:  idle_mode = M_BANG;
               default: begin
                  idle_v          = 1'b1;
                  idle_tok.kind   = single_kind(c);
                  idle_tok.length = TOK_W'(1);
               end
            endcase
         end
      end

      // pending operator decode
      unique case (mode_ff)
         M_EQ: begin
            op_single = K_ASSIGN; op_double = K_EQ_EQ;    op_char = CH_EQ;
         end
         M_PLUS: begin
            op_single = K_PLUS;   op_double = K_PLUS2;    op_char = CH_PLUS;
         end
         M_MINUS: begin
            op_single = K_MINUS;  op_double = K_MINUS2;   op_char = CH_MINUS;
         end
         default: begin
            op_single = K_BANG;   op_double = K_NOT_EQ;   op_char = CH_EQ;
         end
      endcase
      op_match = (c == op_char);

      // token that the open mode closes
      pe_v      = 1'b0;
      call_idle = 1'b0;
      mode_in   = mode_ff;
      begin_in  = begin_ff;
      ended     = 1'b0;
      pe_tok    = '{kind: K_WORD, start: TOK_W'(begin_ff), length: TOK_W'(span),
                    ovf: ovf_ff, last: 1'b0};
      unique case (mode_ff) inside
         M_WORD, M_INT: begin
            if (!((mode_ff == M_WORD && is_letter(c)) || (mode_ff == M_INT && is_digit(c))))
               begin
               pe_v        = 1'b1;
               pe_tok.kind = (mode_ff == M_WORD) ? K_WORD : K_INT;
               call_idle   = 1'b1;
            end
         end
         M_STR: begin
            pe_tok.kind = K_STRING;
            if (c == CH_QUOTE) begin
               pe_v    = 1'b1;
               mode_in = M_IDLE;
            end else if (c == CH_NUL) begin
               // unterminated string runs to the end of input
               pe_v      = 1'b1;
               call_idle = 1'b1;
            end
         end
         M_EQ, M_PLUS, M_MINUS, M_BANG: begin
            pe_v = 1'b1;
            if (op_match) begin
               pe_tok.kind   = op_double;
               pe_tok.length = TOK_W'(2);
               mode_in       = M_IDLE;
            end else begin
               pe_tok.kind   = op_single;
               pe_tok.length = TOK_W'(1);
               call_idle     = 1'b1;
            end
         end
         default: call_idle = 1'b1;
      endcase

      if (call_idle) begin
         mode_in  = idle_mode;
         begin_in = idle_begin;
         ended    = idle_end;
      end

      // order the tokens, closed token first
      n_tok      = {1'b0, pe_v} + {1'b0, call_idle & idle_v};
      slot0      = pe_v ? pe_tok : idle_tok;
      slot0.last = (n_tok == 2'd1);
      slot1      = idle_tok;
      slot1.last = 1'b1;

      // position advance, saturate at the limit, clear at end of input
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (ended) begin
         pos_in   = '0;
         ovf_in   = 1'b0;
         begin_in = '0;
         mode_in  = M_IDLE;
      end else if (p == lim) begin
         ovf_in = 1'b1;
      end else begin
         pos_in = p + 1'b1;
      end
   end

   assign push = req_tvalid & req_tready;
   assign pop  = rsp_tvalid & rsp_tready;

   // queue update: shift out the head on pop, append new tokens behind the rest
   always_comb begin
      logic [1:0] cnt_after;
      logic [1:0] n_push;
      token_type  q_sh [QDEPTH];

      cnt_after = cnt_ff - {1'b0, pop};
      n_push    = push ? n_tok : 2'd0;
      for (int i = 0; i < QDEPTH; i++) begin
         q_sh[i] = (pop && i < QDEPTH - 1) ? q_ff[(i + 1) % QDEPTH] : q_ff[i];
      end
      for (int i = 0; i < QDEPTH; i++) begin
         q_in[i] = q_sh[i];
         if (n_push != 2'd0 && cnt_after == 2'(i)) begin
            q_in[i] = slot0;
         end else if (n_push == 2'd2 && (cnt_after + 2'd1) == 2'(i)) begin
            q_in[i] = slot1;
         end
      end
      cnt_in = cnt_after + n_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         begin_ff <= '0;
         pos_ff   <= '0;
         ovf_ff   <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         if (push) begin
            mode_ff  <= mode_in;
            begin_ff <= begin_in;
            pos_ff   <= pos_in;
            ovf_ff   <= ovf_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign req_tready = (cnt_ff <= 2'd1);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {7'b0, q_ff[0].ovf, q_ff[0].length, q_ff[0].start};
   assign rsp_tuser  = q_ff[0].kind;
   assign rsp_tlast  = q_ff[0].last;

endmodule

FILE: rtl/core/stl_checker.sv
module stl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [4:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import stl_pkg::*;

   // a stalled token beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled token beat changed");

   // a byte waiting for the input stays offered and unchanged
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting source byte changed");

   // end token closes the run of its byte and carries no text
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_END |-> rsp_tlast && rsp_tdata[31:16] == 16'd0)
      else $error("end token not last of run or with nonzero length");

   // illegal bytes are single-byte tokens
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_ILLEGAL |-> rsp_tdata[31:16] == 16'd1)
      else $error("illegal token length not one");

   // two-character operators span two bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == K_EQ_EQ || rsp_tuser == K_PLUS2 || rsp_tuser == K_MINUS2
         || rsp_tuser == K_NOT_EQ) |-> rsp_tdata[31:16] == 16'd2)
      else $error("double operator length not two");

endmodule

bind script_token_lexer_unit stl_checker u_stl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/testbench.sv
// Self-checking bench for the script token lexer.
// Source bytes go in on the req stream, one per beat. The bench keeps its own
// scanner, runs it on every accepted byte, and queues the tokens that byte
// should produce. Each token taken from the rsp stream is compared field by
// field with the oldest queued token.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import stl_pkg::*;

   localparam int LEX_POS_BITS = POS_BITS_DEF;
   localparam logic [LEX_POS_BITS-1:0] POS_MAX = '1;

   // clock, reset and the two stream channels
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] in_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [15:0] tok_start, [31:16] tok_length, [32] overflow
   logic [4:0]  rsp_tuser;            // [4:0] tok_kind
   logic        rsp_tlast;            // last_of_run

   // stimulus bookkeeping
   logic [7:0] pending_bytes[$];
   int         bytes_queued   = 0;
   int         bytes_accepted = 0;
   int         send_idle_pct  = 0;
   int         recv_idle_pct  = 0;
   bit         req_beat_taken = 1'b0;
   bit         stall_arm      = 1'b0;
   bit         stall_done     = 1'b0;
   int         stall_left     = 0;

   // scanner copy and token scoreboard
   logic [2:0]              scan_state  = M_IDLE;
   logic [15:0]             open_begin  = '0;
   logic [LEX_POS_BITS-1:0] cursor      = '0;
   logic                    ovf_flag    = 1'b0;
   token_type               byte_tokens[$];
   token_type               expected_tokens[$];
   token_type               want;
   int                      errors         = 0;
   int                      tokens_checked = 0;
   int                      saturations    = 0;

   script_token_lexer_unit #(
      .POS_BITS (LEX_POS_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Scanner model
   // ------------------------------------------------------------------

   function automatic bit word_char(input logic [7:0] c);
      return (c inside {["a":"z"], ["A":"Z"]}) || c == CH_UNDER;
   endfunction

   function automatic bit num_char(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic longint span_of(input longint from, input longint upto);
      return (upto > from) ? upto - from : 0;
   endfunction

   // Tokens carry the overflow flag as it stands when they are emitted.
   task automatic note_token(input logic [4:0] kind, input logic [15:0] start,
                             input longint len);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = 16'(len);
      t.ovf    = ovf_flag;
      t.last   = 1'b0;
      byte_tokens.push_back(t);
   endtask

   // Handle a byte with no token open; flag a zero byte as end of input.
   task automatic begin_from_idle(input logic [7:0] c, input logic [LEX_POS_BITS-1:0] here,
                                  output logic ended);
      ended      = 1'b0;
      scan_state = M_IDLE;
      if (c == CH_NUL) begin
         note_token(K_END, 16'(here), 0);
         ended = 1'b1;
      end else if (!(c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
         open_begin = 16'(here);
         if (word_char(c)) begin
            scan_state = M_WORD;
         end else if (num_char(c)) begin
            scan_state = M_INT;
         end else begin
            case (c)
               // string text starts after the quote, clamped at the top position
               CH_QUOTE: begin
                  open_begin = (here < POS_MAX) ? 16'(here + 1'b1) : 16'(POS_MAX);
                  scan_state = M_STR;
               end
               CH_EQ:    scan_state = M_EQ;
               CH_PLUS:  scan_state = M_PLUS;
               CH_MINUS: scan_state = M_MINUS;
               CH_BANG:  scan_state = M_BANG;
               "*":      note_token(K_STAR, 16'(here), 1);
               "/":      note_token(K_SLASH, 16'(here), 1);
               "<":      note_token(K_LESS, 16'(here), 1);
               ">":      note_token(K_GREATER, 16'(here), 1);
               ",":      note_token(K_COMMA, 16'(here), 1);
               ";":      note_token(K_SEMI, 16'(here), 1);
               "(":      note_token(K_LPAREN, 16'(here), 1);
               ")":      note_token(K_RPAREN, 16'(here), 1);
               "{":      note_token(K_LBRACE, 16'(here), 1);
               "}":      note_token(K_RBRACE, 16'(here), 1);
               "[":      note_token(K_LBRACKET, 16'(here), 1);
               "]":      note_token(K_RBRACKET, 16'(here), 1);
               ":":      note_token(K_COLON, 16'(here), 1);
               default:  note_token(K_ILLEGAL, 16'(here), 1);
            endcase
         end
      end
   endtask

   // Advance the scanner by one accepted byte and queue the tokens it causes.
   task automatic lex_byte(input logic [7:0] c);
      logic [LEX_POS_BITS-1:0] here;
      logic                    ended;
      logic [7:0]              pair_char;
      logic [4:0]              pair_kind;
      logic [4:0]              lone_kind;
      token_type               t;
      here  = cursor;
      ended = 1'b0;
      byte_tokens.delete();
      case (scan_state)
         M_WORD, M_INT: begin
            // a digit closes a word and a letter closes an integer
            if (!((scan_state == M_WORD && word_char(c)) ||
                  (scan_state == M_INT && num_char(c)))) begin
               note_token((scan_state == M_WORD) ? K_WORD : K_INT, open_begin,
                          span_of(open_begin, here));
               begin_from_idle(c, here, ended);
            end
         end
         M_STR: begin
            if (c == CH_QUOTE) begin
               note_token(K_STRING, open_begin, span_of(open_begin, here));
               scan_state = M_IDLE;
            end else if (c == CH_NUL) begin
               // unterminated string: flush its text, then the end token
               note_token(K_STRING, open_begin, span_of(open_begin, here));
               begin_from_idle(c, here, ended);
            end
         end
         M_EQ, M_PLUS, M_MINUS, M_BANG: begin
            case (scan_state)
               M_EQ: begin
                  pair_char = CH_EQ;
                  pair_kind = K_EQ_EQ;
                  lone_kind = K_ASSIGN;
               end
               M_PLUS: begin
                  pair_char = CH_PLUS;
                  pair_kind = K_PLUS2;
                  lone_kind = K_PLUS;
               end
               M_MINUS: begin
                  pair_char = CH_MINUS;
                  pair_kind = K_MINUS2;
                  lone_kind = K_MINUS;
               end
               default: begin
                  pair_char = CH_EQ;
                  pair_kind = K_NOT_EQ;
                  lone_kind = K_BANG;
               end
            endcase
            if (c == pair_char) begin
               note_token(pair_kind, open_begin, 2);
               scan_state = M_IDLE;
            end else begin
               note_token(lone_kind, open_begin, 1);
               begin_from_idle(c, here, ended);
            end
         end
         default: begin_from_idle(c, here, ended);
      endcase

      // mark the final token of this byte
      if (byte_tokens.size() > 0) begin
         t      = byte_tokens.pop_back();
         t.last = 1'b1;
         byte_tokens.push_back(t);
      end
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);

      if (ended) begin
         cursor     = '0;
         ovf_flag   = 1'b0;
         open_begin = '0;
         scan_state = M_IDLE;
      end else if (here >= POS_MAX) begin
         // hold the position at the top and raise overflow
         if (!ovf_flag) saturations++;
         cursor   = POS_MAX;
         ovf_flag = 1'b1;
      end else begin
         cursor = here + 1'b1;
      end
   endtask

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_beat_taken = 1'b0;
      end else begin
         req_beat_taken = req_tvalid && req_tready;
         if (req_beat_taken) begin
            lex_byte(req_tdata);
            bytes_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: kind %0d start %0d length %0d",
                      rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
               errors++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("tok_kind", want.kind, rsp_tuser);
               check_field("tok_start", want.start, rsp_tdata[15:0]);
               check_field("tok_length", want.length, rsp_tdata[31:16]);
               check_field("overflow", want.ovf, rsp_tdata[32]);
               check_field("last_of_run", want.last, rsp_tlast);
               tokens_checked++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver: hold a byte until its beat is taken, idle at random between
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
      end else if (!req_tvalid || req_beat_taken) begin
         if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, armed once; counts down on its own.
   always @(negedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_done <= 1'b0;
      end else if (stall_arm && !stall_done) begin
         stall_left <= 150;
         stall_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Receiver: drop ready at random, and for the whole hold-off stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_letter();
      int r;
      r = $urandom_range(52);
      if (r < 26) push_byte(8'("a" + r));
      else if (r < 52) push_byte(8'("A" + r - 26));
      else push_byte(CH_UNDER);
   endtask

   // Append one lexeme; noisy lexemes are raw bytes, lone quotes and zeros.
   task automatic add_chunk(input bit noisy);
      string      punct_chars;
      logic [7:0] ops [4];
      logic [7:0] op;
      logic [7:0] b;
      int         sel;
      punct_chars = "*/<>,;(){}[]:";
      ops = '{CH_EQ, CH_PLUS, CH_MINUS, CH_BANG};
      sel = noisy ? $urandom_range(11, 9) : $urandom_range(8, 0);
      case (sel)
         0, 1: repeat ($urandom_range(6, 1)) push_letter();
         2: repeat ($urandom_range(5, 1)) push_byte(8'("0" + $urandom_range(9)));
         3: begin
            push_byte(CH_QUOTE);
            repeat ($urandom_range(5, 0)) begin
               do b = 8'($urandom_range(255, 1)); while (b == CH_QUOTE);
               push_byte(b);
            end
            push_byte(CH_QUOTE);
         end
         4, 5: begin
            op = ops[$urandom_range(3)];
            push_byte(op);
            if ($urandom_range(1)) push_byte((op == CH_BANG) ? CH_EQ : op);
         end
         6, 7: push_byte(8'(punct_chars[$urandom_range(punct_chars.len() - 1)]));
         8: repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(3))
               0: push_byte(CH_SPACE);
               1: push_byte(CH_TAB);
               2: push_byte(CH_CR);
               default: push_byte(CH_LF);
            endcase
         end
         9: push_byte(8'($urandom_range(255, 1)));
         10: push_byte(CH_QUOTE);
         default: push_byte(CH_NUL);
      endcase
   endtask

   // One source line: mostly well-formed lexemes, closed by a zero byte.
   task automatic add_line();
      repeat ($urandom_range(12, 3)) begin
         add_chunk($urandom_range(4) == 0);
         if ($urandom_range(1)) push_byte(CH_SPACE);
      end
      push_byte(CH_NUL);
   endtask

   task automatic wait_accepted();
      while (bytes_accepted != bytes_queued) @(posedge clock);
   endtask

   // Edge cases: word/int boundaries, empty string, all paired operators,
   // lookahead flush, high bytes, unterminated string, pending op at end,
   // empty input.
   logic [7:0] opening_bytes [29] = '{
      CH_UNDER, "Z", "9", "a", CH_TAB, CH_QUOTE, CH_QUOTE,
      CH_EQ, CH_EQ, CH_BANG, CH_EQ, CH_PLUS, CH_PLUS, CH_MINUS, CH_MINUS,
      CH_BANG, "*", 8'h80, 8'hFF, CH_CR, CH_LF, CH_SPACE, CH_QUOTE, "q",
      CH_NUL, CH_MINUS, CH_NUL, CH_NUL, 8'h7F
   };

   initial begin
      int drain;
      int phase_start;

      send_idle_pct = 14;
      recv_idle_pct = 64;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // phase one: light sender gaps, heavy receiver stalls
      foreach (opening_bytes[i]) push_byte(opening_bytes[i]);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 210) add_line();
      wait_accepted();

      // phase two: the other way round
      send_idle_pct = 64;
      recv_idle_pct = 14;
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 230) add_line();
      wait_accepted();

      // phase three: no idling; hold the receiver off so the block backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_arm     = 1'b1;
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 230) add_line();

      // string right after a string, whose text holds a space, a letter, a digit and an
      // operator, then a word closed by the end of input
      push_byte(CH_QUOTE);
      push_byte("a");
      push_byte("b");
      push_byte(CH_QUOTE);
      push_byte(CH_QUOTE);
      push_byte(CH_SPACE);
      push_byte("x");
      push_byte("7");
      push_byte(CH_PLUS);
      push_byte(CH_QUOTE);
      push_byte("q");
      push_byte(CH_NUL);
      // after the end token the position starts over
      add_line();
      wait_accepted();

      // let the last tokens drain, then leave room for stragglers before the summary
      drain = 0;
      while (expected_tokens.size() > 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      if (expected_tokens.size() > 0) begin
         $error("%0d expected tokens never arrived", expected_tokens.size());
         errors += expected_tokens.size();
      end
      repeat (20) @(posedge clock);

      $display("summary: %0d source bytes scanned, %0d tokens compared", bytes_accepted,
               tokens_checked);
      $display("summary: three idling mixes, one long receiver hold, %0d position saturations",
               saturations);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #(10_000_000);
      $display("testbench: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/stl_pkg.sv
rtl/core/script_token_lexer_unit.sv
rtl/core/stl_checker.sv
tb/testbench.sv
